/* hw/rtl/lrsps_pkg.sv */
// ----------------------------------------------------------------------------
// lrsps_pkg
// Shared types and constants of the LED ring status pattern sequencer.
// ----------------------------------------------------------------------------
package lrsps_pkg;

	localparam int OP_W    = 2;
	localparam int NOW_W   = 32;
	localparam int MODE_W  = 3;
	localparam int IDX_W   = 5;
	localparam int CH_W    = 8;
	localparam int PCT_W   = 7;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_SET  = 2'd1;
	localparam logic [OP_W-1:0] OP_DIAG = 2'd2;

	localparam logic [MODE_W-1:0] MODE_OFF        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RED_BLINK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RED        = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ALT_GB     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GRN_BLINK  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_GREEN      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPINNER    = 3'd6;
	localparam logic [MODE_W-1:0] MODE_FLASH      = 3'd7;

	localparam logic [NOW_W-1:0] RED_BLINK_MS = 32'd350;
	localparam logic [NOW_W-1:0] ALT_BLINK_MS = 32'd450;
	localparam logic [NOW_W-1:0] SPIN_MS      = 32'd180;
	localparam logic [NOW_W-1:0] FLASH_MS     = 32'd200;
	localparam logic [NOW_W-1:0] DIAG_MS      = 32'd400;

	localparam logic [CH_W-1:0] LVL_100  = 8'd100;
	localparam logic [CH_W-1:0] LVL_90   = 8'd90;
	localparam logic [CH_W-1:0] LVL_DIAG = 8'd60;

	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [CH_W-1:0]  SB_FULL   = 8'd255;
	// floor(x/100) == (x*5243)>>19 for x <= 99*255
	localparam logic [12:0]      RECIP_100 = 13'd5243;
	localparam int               RECIP_SH  = 19;

	typedef struct packed {
		logic accept;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic frame_req;
		logic last_pix;
	} sts_t;

endpackage

/* hw/rtl/lrsps_if.sv */
// ----------------------------------------------------------------------------
// lrsps_if
// Item channels of the LED ring sequencer: input items and pixel items.
// ----------------------------------------------------------------------------
interface lrsps_in_if;
	logic                             valid;
	logic                             ready;
	logic [lrsps_pkg::OP_W-1:0]       operation;
	logic [lrsps_pkg::NOW_W-1:0]      now_ms;
	logic [lrsps_pkg::MODE_W-1:0]     new_mode;

	modport source (output valid, output operation, output now_ms, output new_mode,
		input ready);
	modport sink (input valid, input operation, input now_ms, input new_mode,
		output ready);
endinterface

interface lrsps_out_if;
	logic                             valid;
	logic                             ready;
	logic [lrsps_pkg::IDX_W-1:0]      pixel_index;
	logic [lrsps_pkg::CH_W-1:0]       red;
	logic [lrsps_pkg::CH_W-1:0]       green;
	logic [lrsps_pkg::CH_W-1:0]       blue;
	logic                             last_pixel;

	modport source (output valid, output pixel_index, output red, output green,
		output blue, output last_pixel, input ready);
	modport sink (input valid, input pixel_index, input red, input green,
		input blue, input last_pixel, output ready);
endinterface

/* hw/rtl/lrsps_ctrl.sv */
// ----------------------------------------------------------------------------
// lrsps_ctrl
// Handshake controller: takes items, runs frame emission, owns output valid.
// ----------------------------------------------------------------------------
module lrsps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lrsps_pkg::sts_t   sts,
	output lrsps_pkg::cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic ovalid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = ovalid_q;
	assign cmd.accept = in_valid && in_ready;
	assign cmd.load   = (state_q == ST_EMIT) && (!ovalid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept && sts.frame_req) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.load && sts.last_pix) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/lrsps_dp.sv */
// ----------------------------------------------------------------------------
// lrsps_dp
// Sequencer state, timer decisions, pixel counters and the output register.
// ----------------------------------------------------------------------------
module lrsps_dp #(
	parameter int RING_PIXELS      = 24,
	parameter int PIXELS_PER_GROUP = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lrsps_pkg::cmd_t                   cmd,
	output lrsps_pkg::sts_t                   sts,
	input  logic [lrsps_pkg::OP_W-1:0]        operation,
	input  logic [lrsps_pkg::NOW_W-1:0]       now_ms,
	input  logic [lrsps_pkg::MODE_W-1:0]      new_mode,
	input  logic [lrsps_pkg::CH_W-1:0]        scale,
	output logic [lrsps_pkg::IDX_W-1:0]       pixel_index,
	output logic [lrsps_pkg::CH_W-1:0]        red,
	output logic [lrsps_pkg::CH_W-1:0]        green,
	output logic [lrsps_pkg::CH_W-1:0]        blue,
	output logic                              last_pixel
);

	localparam int GROUP_COUNT = (RING_PIXELS + PIXELS_PER_GROUP - 1) / PIXELS_PER_GROUP;
	localparam int PW = $clog2(RING_PIXELS + 1);
	localparam int GW = $clog2(GROUP_COUNT + 1);
	localparam int SW = $clog2(PIXELS_PER_GROUP + 1);
	localparam int IW = lrsps_pkg::IDX_W;
	localparam int NW = lrsps_pkg::NOW_W;
	localparam int MW = lrsps_pkg::MODE_W;
	localparam int CW = lrsps_pkg::CH_W;

	localparam logic [PW-1:0] PIX_LAST  = PW'(RING_PIXELS - 1);
	localparam logic [PW-1:0] PIX_COUNT = PW'(RING_PIXELS);
	localparam logic [GW-1:0] GRP_LAST  = GW'(GROUP_COUNT - 1);
	localparam logic [SW-1:0] SUB_LAST  = SW'(PIXELS_PER_GROUP - 1);

	// sequencer state
	logic [MW-1:0] mode_q;
	logic          dirty_q;
	logic [NW-1:0] phase_q;
	logic          blink_q;
	logic [GW-1:0] spin_q;
	logic          run_q;
	logic [PW-1:0] dpos_q;
	logic [NW-1:0] due_q;

	// frame being emitted
	logic          diag_q;
	logic          lit_en_q;
	logic [PW-1:0] lit_q;
	logic [PW-1:0] pix_q;
	logic [GW-1:0] grp_q;
	logic [SW-1:0] sub_q;

	logic [MW-1:0] nx_mode;
	logic          nx_dirty;
	logic [NW-1:0] nx_phase;
	logic          nx_blink;
	logic [GW-1:0] nx_spin;
	logic          nx_run;
	logic [PW-1:0] nx_dpos;
	logic [NW-1:0] nx_due;
	logic          nx_diag;
	logic          nx_lit_en;
	logic [PW-1:0] nx_lit;
	logic          frame_req;

	logic [NW-1:0] elapsed;
	logic [NW-1:0] period;
	logic          timed;

	logic [15:0]   p100;
	logic [15:0]   p90;
	logic [CW-1:0] s100;
	logic [CW-1:0] s90;
	logic [CW-1:0] pr;
	logic [CW-1:0] pg;
	logic [CW-1:0] pb;

	assign elapsed = now_ms - phase_q;

	always_comb begin
		case (mode_q)
			lrsps_pkg::MODE_RED_BLINK: period = lrsps_pkg::RED_BLINK_MS;
			lrsps_pkg::MODE_ALT_GB:    period = lrsps_pkg::ALT_BLINK_MS;
			lrsps_pkg::MODE_GRN_BLINK: period = lrsps_pkg::ALT_BLINK_MS;
			lrsps_pkg::MODE_SPINNER:   period = lrsps_pkg::SPIN_MS;
			lrsps_pkg::MODE_FLASH:     period = lrsps_pkg::FLASH_MS;
			default:                   period = '1;
		endcase
	end

	assign timed = (elapsed >= period);

	always_comb begin
		nx_mode   = mode_q;
		nx_dirty  = dirty_q;
		nx_phase  = phase_q;
		nx_blink  = blink_q;
		nx_spin   = spin_q;
		nx_run    = run_q;
		nx_dpos   = dpos_q;
		nx_due    = due_q;
		nx_diag   = 1'b0;
		nx_lit_en = 1'b0;
		nx_lit    = dpos_q;
		frame_req = 1'b0;
		case (operation)
			lrsps_pkg::OP_SET: begin
				if (new_mode != mode_q) begin
					nx_mode  = new_mode;
					nx_phase = now_ms;
					nx_blink = (new_mode == lrsps_pkg::MODE_GRN_BLINK);
					nx_spin  = '0;
					nx_dirty = 1'b1;
				end
			end
			lrsps_pkg::OP_DIAG: begin
				nx_run  = 1'b1;
				nx_dpos = '0;
				nx_due  = '0;
			end
			lrsps_pkg::OP_TICK: begin
				if (run_q) begin
					if (now_ms >= due_q) begin
						nx_due    = now_ms + lrsps_pkg::DIAG_MS;
						frame_req = 1'b1;
						nx_diag   = 1'b1;
						if (dpos_q < PIX_COUNT) begin
							nx_lit_en = 1'b1;
							nx_dpos   = dpos_q + PW'(1);
						end else begin
							nx_dpos = '0;
						end
					end
				end else begin
					if (timed) begin
						case (mode_q)
							lrsps_pkg::MODE_RED_BLINK,
							lrsps_pkg::MODE_ALT_GB,
							lrsps_pkg::MODE_GRN_BLINK: begin
								nx_phase = now_ms;
								nx_dirty = 1'b1;
								nx_blink = !blink_q;
							end
							lrsps_pkg::MODE_SPINNER: begin
								nx_phase = now_ms;
								nx_dirty = 1'b1;
								nx_spin  = (spin_q == GRP_LAST) ? '0 : spin_q + GW'(1);
							end
							lrsps_pkg::MODE_FLASH: begin
								nx_mode  = lrsps_pkg::MODE_GREEN;
								nx_phase = now_ms;
								nx_blink = 1'b0;
								nx_spin  = '0;
								nx_dirty = 1'b1;
							end
							default: begin
							end
						endcase
					end
					frame_req = nx_dirty;
					nx_dirty  = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.frame_req = frame_req;
	assign sts.last_pix  = (pix_q == PIX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lrsps_pkg::MODE_OFF;
			dirty_q <= 1'b1;
			phase_q <= '0;
			blink_q <= 1'b0;
			spin_q  <= '0;
			run_q   <= 1'b0;
			dpos_q  <= '0;
			due_q   <= '0;
		end else if (cmd.accept) begin
			mode_q  <= nx_mode;
			dirty_q <= nx_dirty;
			phase_q <= nx_phase;
			blink_q <= nx_blink;
			spin_q  <= nx_spin;
			run_q   <= nx_run;
			dpos_q  <= nx_dpos;
			due_q   <= nx_due;
		end
	end

	// scaled levels: ((c*b)>>8) + (c!=0 && b!=0)
	assign p100 = 16'(lrsps_pkg::LVL_100) * {8'd0, scale};
	assign p90  = 16'(lrsps_pkg::LVL_90) * {8'd0, scale};
	assign s100 = p100[15:8] + {7'd0, (scale != '0)};
	assign s90  = p90[15:8] + {7'd0, (scale != '0)};

	always_comb begin
		pr = '0;
		pg = '0;
		pb = '0;
		if (diag_q) begin
			if (lit_en_q && (pix_q == lit_q)) begin
				pr = lrsps_pkg::LVL_DIAG;
				pg = lrsps_pkg::LVL_DIAG;
				pb = lrsps_pkg::LVL_DIAG;
			end
		end else begin
			case (mode_q)
				lrsps_pkg::MODE_RED_BLINK: if (blink_q) pr = s100;
				lrsps_pkg::MODE_RED:       pr = s100;
				lrsps_pkg::MODE_ALT_GB: begin
					if ((grp_q[0] == 1'b0) == blink_q) begin
						if (blink_q) pg = s90;
						else pb = s100;
					end
				end
				lrsps_pkg::MODE_GRN_BLINK: if (blink_q) pg = s90;
				lrsps_pkg::MODE_GREEN:     pg = s90;
				lrsps_pkg::MODE_SPINNER:   if (grp_q == spin_q) pb = s100;
				lrsps_pkg::MODE_FLASH: begin
					pg = s90;
					pb = s90;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			diag_q   <= nx_diag;
			lit_en_q <= nx_lit_en;
			lit_q    <= nx_lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			grp_q <= '0;
			sub_q <= '0;
		end else if (cmd.accept) begin
			pix_q <= '0;
			grp_q <= '0;
			sub_q <= '0;
		end else if (cmd.load) begin
			pix_q <= pix_q + PW'(1);
			if (sub_q == SUB_LAST) begin
				sub_q <= '0;
				grp_q <= grp_q + GW'(1);
			end else begin
				sub_q <= sub_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_index <= IW'(pix_q);
			red         <= pr;
			green       <= pg;
			blue        <= pb;
			last_pixel  <= (pix_q == PIX_LAST);
		end
	end

endmodule

/* hw/rtl/led_ring_status_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// led_ring_status_pattern_sequencer
// Status LED ring pattern sequencer with APB brightness register.
// ----------------------------------------------------------------------------
// A set-mode item, a diagnostic-start item and a tick that leaves the frame
// unchanged are each taken without emitting pixels. A tick that yields a frame
// is followed by RING_PIXELS pixels, one pixel a cycle out of the single output
// register, slower while the pixel sink holds ready low; the next item is
// taken once the last pixel is loaded. The brightness register (byte address
// 0) is decoded to a scale byte at write time.
module led_ring_status_pattern_sequencer #(
	parameter int RING_PIXELS      = 24,
	parameter int PIXELS_PER_GROUP = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lrsps_pkg::ADDR_W-1:0]       paddr,
	input  logic [lrsps_pkg::DATA_W-1:0]       pwdata,
	output logic [lrsps_pkg::DATA_W-1:0]       prdata,
	output logic                               pready,
	lrsps_in_if.sink                           in_item,
	lrsps_out_if.source                        out_item
);

	localparam int PCW = lrsps_pkg::PCT_W;
	localparam int CW  = lrsps_pkg::CH_W;

	logic [PCW-1:0]  pct_q;
	logic [CW-1:0]   sb_q;
	logic            reg_hit;
	logic            wr_en;
	logic [PCW-1:0]  wr_pct;
	logic [14:0]     wr_x;
	logic [27:0]     wr_y;
	logic [CW-1:0]   wr_sb;

	lrsps_pkg::cmd_t cmd;
	lrsps_pkg::sts_t sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'b0);
	assign wr_en   = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {{(lrsps_pkg::DATA_W - PCW){1'b0}}, pct_q} : '0;

	// percent*255/100 by reciprocal
	assign wr_pct = pwdata[PCW-1:0];
	assign wr_x   = {wr_pct, 8'd0} - {8'd0, wr_pct};
	assign wr_y   = {13'd0, wr_x} * {15'd0, lrsps_pkg::RECIP_100};
	assign wr_sb  = (wr_pct >= lrsps_pkg::PCT_FULL) ? lrsps_pkg::SB_FULL
		: wr_y[lrsps_pkg::RECIP_SH +: CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= lrsps_pkg::PCT_FULL;
			sb_q  <= lrsps_pkg::SB_FULL;
		end else if (wr_en) begin
			pct_q <= wr_pct;
			sb_q  <= wr_sb;
		end
	end

	lrsps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_item.valid),
		.in_ready  (in_item.ready),
		.out_valid (out_item.valid),
		.out_ready (out_item.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lrsps_dp #(
		.RING_PIXELS      (RING_PIXELS),
		.PIXELS_PER_GROUP (PIXELS_PER_GROUP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (in_item.operation),
		.now_ms      (in_item.now_ms),
		.new_mode    (in_item.new_mode),
		.scale       (sb_q),
		.pixel_index (out_item.pixel_index),
		.red         (out_item.red),
		.green       (out_item.green),
		.blue        (out_item.blue),
		.last_pixel  (out_item.last_pixel)
	);

endmodule
